// File: hdl/slc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, codes and constants of the sliced limit counter.
// ----------------------------------------------------------------------------
package slc_pkg;

   localparam int REQUESTERS = 16;
   localparam int IDX_W      = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   localparam int SLICE_W    = 16;
   localparam int SUM_W      = SLICE_W + $clog2(REQUESTERS + 1);
   localparam int CNT_W      = 32;
   localparam int DIV_W      = 32;
   localparam int DVSR_W     = 5;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]   GLOBAL_LIMIT_RESET   = 32'd10000;
   localparam logic [SLICE_W-1:0] SLICE_CAP_RESET      = 16'd100;
   localparam logic [DVSR_W-1:0]  THREADS_ONLINE_RESET = 5'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOBAL_LIMIT   = 2'd0,
      CSR_SLICE_CAP      = 2'd1,
      CSR_THREADS_ONLINE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SUB   = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  requester;
      logic [31:0] delta;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [31:0] total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FOLD,
      ST_GLOBAL,
      ST_HEAD,
      ST_DIV,
      ST_REFILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_item;
      logic do_local;
      logic do_fold;
      logic do_global;
      logic div_start;
      logic do_refill;
      logic ok_set;
      logic ok_clr;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       req_ok;
      logic       local_ok;
      logic       global_ok;
      logic       div_done;
   } status_type;

endpackage

// File: hdl/slc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_divider
// Restoring divider, one quotient bit per cycle, for the slice share.
// ----------------------------------------------------------------------------
module slc_divider
   import slc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 div_start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DVSR_W-1:0]    divisor,
   output logic                 div_done,
   output logic [DIV_W-1:0]     quotient
);

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     work_ff, work_in;
   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DVSR_W:0]      trial;

   always_comb begin
      trial    = {rem_ff, work_ff[DIV_W-1]};
      count_in = count_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      if (div_start) begin
         count_in = DIV_CNT_W'(DIV_W);
         work_in  = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in  = DVSR_W'(trial - {1'b0, divisor});
            work_in = {work_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVSR_W-1:0];
            work_in = {work_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign div_done = (count_ff == '0);
   assign quotient = work_ff;

endmodule

// File: hdl/slc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_datapath
// Configuration, global count, reserve and slice registers with their update
// logic, and the divider that sizes a refilled slice.
// ----------------------------------------------------------------------------
module slc_datapath
   import slc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_type               rsp_data
);

   logic [CNT_W-1:0]   global_limit_ff;
   logic [SLICE_W-1:0] slice_cap_ff;
   logic [DVSR_W-1:0]  threads_online_ff;

   req_type            item_ff;
   logic               ok_ff, ok_in;
   logic [CNT_W-1:0]   gc_ff, gc_in;
   logic [CNT_W-1:0]   res_ff, res_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SLICE_W-1:0] slice_cnt_ff [REQUESTERS];
   logic [SLICE_W-1:0] slice_lim_ff [REQUESTERS];
   logic [SLICE_W-1:0] slice_cnt_in, slice_lim_in;
   logic               slice_we;

   logic [IDX_W-1:0]   idx;
   logic [SLICE_W-1:0] cur_cnt, cur_lim, room;
   logic [CNT_W:0]     used, fold_sum, tot_sum;
   logic [CNT_W-1:0]   head;
   logic [DVSR_W-1:0]  divisor;
   logic               div_done;
   logic [DIV_W-1:0]   quotient;
   logic [SLICE_W-1:0] lim_new, cnt_half, cnt_new;

   slc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (cmd.div_start),
      .dividend  (head),
      .divisor   (divisor),
      .div_done  (div_done),
      .quotient  (quotient)
   );

   always_comb begin
      idx      = item_ff.requester[IDX_W-1:0];
      cur_cnt  = slice_cnt_ff[idx];
      cur_lim  = slice_lim_ff[idx];
      room     = (cur_lim > cur_cnt) ? SLICE_W'(cur_lim - cur_cnt) : '0;
      used     = {1'b0, gc_ff} + {1'b0, res_ff};
      head     = (used >= {1'b0, global_limit_ff}) ? '0
                 : CNT_W'(global_limit_ff - used[CNT_W-1:0]);
      divisor  = (threads_online_ff == '0) ? DVSR_W'(1) : threads_online_ff;
      lim_new  = (quotient > {16'd0, slice_cap_ff}) ? slice_cap_ff
                 : quotient[SLICE_W-1:0];
      cnt_half = {1'b0, lim_new[SLICE_W-1:1]};
      cnt_new  = ({16'd0, cnt_half} > gc_ff) ? gc_ff[SLICE_W-1:0] : cnt_half;
      fold_sum = {1'b0, gc_ff} + {17'd0, cur_cnt};
      tot_sum  = {1'b0, gc_ff} + (CNT_W + 1)'(sum_ff);

      status.op       = item_ff.operation;
      status.req_ok   = (int'(item_ff.requester) < REQUESTERS);
      status.local_ok = (item_ff.operation == OP_ADD)
                        ? ({16'd0, room} >= item_ff.delta)
                        : ({16'd0, cur_cnt} >= item_ff.delta);
      status.global_ok = (item_ff.operation == OP_ADD)
                         ? (head >= item_ff.delta)
                         : (gc_ff >= item_ff.delta);
      status.div_done = div_done;

      rsp_data.success = ok_ff;
      rsp_data.total   = tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
   end

   always_comb begin
      ok_in        = ok_ff;
      gc_in        = gc_ff;
      res_in       = res_ff;
      sum_in       = sum_ff;
      slice_we     = 1'b0;
      slice_cnt_in = cur_cnt;
      slice_lim_in = cur_lim;
      if (cmd.ok_set) begin
         ok_in = 1'b1;
      end else if (cmd.ok_clr) begin
         ok_in = 1'b0;
      end
      if (cmd.do_local) begin
         slice_we = 1'b1;
         if (item_ff.operation == OP_ADD) begin
            slice_cnt_in = cur_cnt + item_ff.delta[SLICE_W-1:0];
            sum_in       = sum_ff + SUM_W'(item_ff.delta[SLICE_W-1:0]);
         end else begin
            slice_cnt_in = cur_cnt - item_ff.delta[SLICE_W-1:0];
            sum_in       = sum_ff - SUM_W'(item_ff.delta[SLICE_W-1:0]);
         end
      end
      if (cmd.do_fold) begin
         slice_we     = 1'b1;
         slice_cnt_in = '0;
         slice_lim_in = '0;
         gc_in        = fold_sum[CNT_W] ? '1 : fold_sum[CNT_W-1:0];
         res_in       = (res_ff >= {16'd0, cur_lim}) ? (res_ff - {16'd0, cur_lim}) : '0;
         sum_in       = sum_ff - SUM_W'(cur_cnt);
      end
      if (cmd.do_global) begin
         if (item_ff.operation == OP_ADD) begin
            gc_in = gc_ff + item_ff.delta;
         end else begin
            gc_in = gc_ff - item_ff.delta;
         end
      end
      if (cmd.do_refill) begin
         slice_we     = 1'b1;
         slice_lim_in = lim_new;
         slice_cnt_in = cnt_new;
         res_in       = res_ff + {16'd0, lim_new};
         gc_in        = gc_ff - {16'd0, cnt_new};
         sum_in       = sum_ff + SUM_W'(cnt_new);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_limit_ff   <= GLOBAL_LIMIT_RESET;
         slice_cap_ff      <= SLICE_CAP_RESET;
         threads_online_ff <= THREADS_ONLINE_RESET;
         ok_ff             <= 1'b0;
         gc_ff             <= '0;
         res_ff            <= '0;
         sum_ff            <= '0;
         for (int i = 0; i < REQUESTERS; i++) begin
            slice_cnt_ff[i] <= '0;
            slice_lim_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_GLOBAL_LIMIT:   global_limit_ff   <= csr_wdata;
               CSR_SLICE_CAP:      slice_cap_ff      <= csr_wdata[SLICE_W-1:0];
               CSR_THREADS_ONLINE: threads_online_ff <= csr_wdata[DVSR_W-1:0];
               default: ;
            endcase
         end
         ok_ff  <= ok_in;
         gc_ff  <= gc_in;
         res_ff <= res_in;
         sum_ff <= sum_in;
         if (slice_we) begin
            slice_cnt_ff[idx] <= slice_cnt_in;
            slice_lim_ff[idx] <= slice_lim_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

`ifndef ASSERT_OFF
   a_local_add_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_local && item_ff.operation == OP_ADD)
      |=> slice_cnt_ff[idx] <= slice_lim_ff[idx])
      else $error("Local add left a slice count above its limit.");

   a_refill_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.do_refill |=> slice_lim_ff[idx] <= slice_cap_ff)
      else $error("Refilled slice limit exceeds the slice cap.");

   a_refill_half: assert property (@(posedge clock) disable iff (reset)
      cmd.do_refill |=> slice_cnt_ff[idx] <= (slice_lim_ff[idx] >> 1))
      else $error("Refilled slice count exceeds half of its limit.");
`endif

endmodule

// File: hdl/slc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer that walks an item through the local check, fold, global check,
// division and refill steps and issues the datapath commands.
// ----------------------------------------------------------------------------
module slc_ctrl
   import slc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.req_ok || (status.op != OP_ADD && status.op != OP_SUB &&
                                   status.op != OP_FLUSH)) begin
               cmd.ok_clr = 1'b1;
               state_in   = ST_RESP;
            end else if (status.op == OP_FLUSH || !status.local_ok) begin
               state_in = ST_FOLD;
            end else begin
               cmd.do_local = 1'b1;
               cmd.ok_set   = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_FOLD: begin
            cmd.do_fold = 1'b1;
            if (status.op == OP_FLUSH) begin
               cmd.ok_set = 1'b1;
               state_in   = ST_RESP;
            end else begin
               state_in = ST_GLOBAL;
            end
         end
         ST_GLOBAL: begin
            if (status.global_ok) begin
               cmd.do_global = 1'b1;
               state_in      = ST_HEAD;
            end else begin
               cmd.ok_clr = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_HEAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_REFILL;
            end
         end
         ST_REFILL: begin
            cmd.do_refill = 1'b1;
            cmd.ok_set    = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            busy      = 1'b0;
            rsp_valid = 1'b1;
            if (start) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_resp_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |-> ($past(state_ff) == ST_CHECK ||
                                 $past(state_ff) == ST_FOLD ||
                                 $past(state_ff) == ST_GLOBAL ||
                                 $past(state_ff) == ST_REFILL))
      else $error("Result strobe without a deciding step before it.");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("Divider reports done right after a start.");

   a_refill_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.do_refill |-> ($past(state_ff) == ST_DIV && $past(status.div_done)))
      else $error("Slice refill without a finished division.");
`endif

endmodule

// File: hdl/sliced_limit_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliced_limit_counter_unit
// Bounded shared counter with per-requester slices refilled from the global
// headroom.
// ----------------------------------------------------------------------------
// Channel   Ports                           Transfer
// request   start, busy, req_data           start high while busy is low
// result    rsp_valid, rsp_data             every cycle rsp_valid is high
// config    csr_write, csr_index, csr_wdata every cycle csr_write is high
//
// A local add or subtract, or an unused operation code, shows its result after
// the check step; a flush also passes the fold step, and a refused global check
// passes the fold and global steps. A slice refill passes the check, fold, global,
// head, division and refill steps; its divider makes one quotient bit per cycle.
// A new request is taken in the cycle its predecessor's result is shown.
// Synchronous reset returns control, config, counts and slices to reset values;
// the receiver cannot stall.
module sliced_limit_counter_unit
   import slc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   slc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   slc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
